@@ hdl/crs_pkg.sv @@
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants of the cost rank sorter: widths, register map
// and the entry and control records passed along the cell chain.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int unsigned MAX_LOCATIONS_DEF = 64;
    localparam int unsigned COST_W            = 32;
    localparam int unsigned IDX_W             = 6;
    localparam int unsigned PADDR_W           = 3;
    localparam int unsigned PDATA_W           = 32;

    localparam logic [PADDR_W-1:0] REG_COST_CEILING = 3'd0;

    localparam logic [COST_W-1:0] COST_MOST_NEG   = 32'h8000_0000;
    localparam logic [COST_W-1:0] COST_MOST_POS   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [COST_W-1:0] key;
        logic [IDX_W-1:0]  idx;
    } crs_entry_t;

    typedef struct packed {
        logic              insert;
        logic              drain;
        logic [COST_W-1:0] new_key;
        logic [IDX_W-1:0]  new_idx;
    } crs_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } crs_state_t;

endpackage

@@ hdl/cost_rank_sorter.sv @@
// ----------------------------------------------------------------------------
// cost_rank_sorter
// Ranks one client's location costs and streams the location indices out,
// cheapest first, ties to the smaller index.
// ----------------------------------------------------------------------------
// While loading, the block takes one cost beat per cycle: every cell of the
// chain compares its stored key with the incoming cost in the same cycle and
// the chain opens a slot at the sorted position. The beat marked last starts
// the drain; then s_ready is low and one index beat leaves per cycle (when
// m_ready allows) from the head of the chain, until every stored location of
// the run has left. Capacity is MAX_LOCATIONS; extra costs
// are dropped and reported through m_overflowed on the final beat, which also
// carries the largest cost below the cost_ceiling register (byte address 0).
// ----------------------------------------------------------------------------
module cost_rank_sorter
    import crs_pkg::*;
#(
    parameter int unsigned MAX_LOCATIONS = MAX_LOCATIONS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COST_W-1:0]  s_cost,
    input  logic                      s_is_last,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [IDX_W-1:0]          m_location_index,
    output logic                      m_last_rank,
    output logic signed [COST_W-1:0]  m_max_finite_cost,
    output logic                      m_none_finite,
    output logic                      m_overflowed
);

    localparam int unsigned CNT_W = $clog2(MAX_LOCATIONS + 1);

    crs_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [COST_W-1:0]   ceiling_reg;
    logic [COST_W-1:0]   run_max_reg, run_max_next;
    logic                any_fin_reg, any_fin_next;
    logic                drop_reg, drop_next;
    logic [COST_W-1:0]   fin_max_reg;
    logic                fin_none_reg;
    logic                fin_ovf_reg;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_idx_reg;
    logic                m_last_reg;
    logic [COST_W-1:0]   m_max_reg;
    logic                m_none_reg;
    logic                m_ovf_reg;

    logic                accept;
    logic                full;
    logic                insert;
    logic                is_finite;
    logic                out_load;
    crs_ctrl_t           ctrl;

    crs_entry_t          entry_w [MAX_LOCATIONS];
    logic                gt_w    [MAX_LOCATIONS];

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_COST_CEILING) ? ceiling_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= COST_MOST_POS;
        end else if (psel && penable && pwrite && (paddr == REG_COST_CEILING)) begin
            ceiling_reg <= pwdata;
        end
    end

    // Handshake and chain control
    assign s_ready   = (state_reg == ST_LOAD);
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(MAX_LOCATIONS));
    assign insert    = accept && !full;
    assign is_finite = ($signed(s_cost) < $signed(ceiling_reg));
    assign out_load  = (state_reg == ST_DRAIN) && (!m_valid_reg || m_ready);

    assign ctrl.insert  = insert;
    assign ctrl.drain   = out_load;
    assign ctrl.new_key = s_cost;
    assign ctrl.new_idx = IDX_W'(count_reg);

    generate
        for (genvar i = 0; i < MAX_LOCATIONS; i++) begin : g_cell
            crs_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (CNT_W'(i) < count_reg),
                .left_gt     ((i == 0) ? 1'b0 : gt_w[(i == 0) ? 0 : i - 1]),
                .left_entry  (entry_w[(i == 0) ? 0 : i - 1]),
                .right_entry (entry_w[(i == MAX_LOCATIONS - 1) ? i : i + 1]),
                .entry       (entry_w[i]),
                .gt          (gt_w[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        run_max_next = run_max_reg;
        any_fin_next = any_fin_reg;
        drop_next    = drop_reg;

        if (insert) begin
            count_next = count_reg + 1'b1;
            if (is_finite) begin
                if (!any_fin_reg || ($signed(s_cost) > $signed(run_max_reg))) begin
                    run_max_next = s_cost;
                end
                any_fin_next = 1'b1;
            end
        end else if (accept) begin
            drop_next = 1'b1;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (accept && s_is_last) begin
                    state_next = ST_DRAIN;
                    rem_next   = count_next;
                    count_next = '0;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    rem_next = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            rem_reg     <= '0;
            run_max_reg <= COST_MOST_NEG;
            any_fin_reg <= 1'b0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            if (accept && s_is_last) begin
                run_max_reg <= COST_MOST_NEG;
                any_fin_reg <= 1'b0;
                drop_reg    <= 1'b0;
            end else begin
                run_max_reg <= run_max_next;
                any_fin_reg <= any_fin_next;
                drop_reg    <= drop_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Run summary and output register
    always_ff @(posedge aclk) begin
        if (accept && s_is_last) begin
            fin_max_reg  <= run_max_next;
            fin_none_reg <= !any_fin_next;
            fin_ovf_reg  <= drop_next;
        end
        if (out_load) begin
            m_idx_reg  <= entry_w[0].idx;
            m_last_reg <= (rem_reg == CNT_W'(1));
            m_max_reg  <= (rem_reg == CNT_W'(1)) ? fin_max_reg : '0;
            m_none_reg <= (rem_reg == CNT_W'(1)) && fin_none_reg;
            m_ovf_reg  <= (rem_reg == CNT_W'(1)) && fin_ovf_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_location_index  = m_idx_reg;
    assign m_last_rank       = m_last_reg;
    assign m_max_finite_cost = m_max_reg;
    assign m_none_finite     = m_none_reg;
    assign m_overflowed      = m_ovf_reg;

endmodule

@@ hdl/crs_cell.sv @@
// ----------------------------------------------------------------------------
// crs_cell
// One cell of the insertion chain. Holds one (cost, index) entry, compares
// it with the broadcast key and takes the new key, its left neighbor's entry
// or, while draining, its right neighbor's entry.
// ----------------------------------------------------------------------------
module crs_cell
    import crs_pkg::*;
(
    input  logic       aclk,
    input  crs_ctrl_t  ctrl,
    input  logic       occupied,
    input  logic       left_gt,
    input  crs_entry_t left_entry,
    input  crs_entry_t right_entry,
    output crs_entry_t entry,
    output logic       gt
);

    crs_entry_t entry_reg;
    crs_entry_t entry_next;

    assign gt = !occupied || ($signed(entry_reg.key) > $signed(ctrl.new_key));

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.drain) begin
            entry_next = right_entry;
        end else if (ctrl.insert && gt) begin
            if (left_gt) begin
                entry_next = left_entry;
            end else begin
                entry_next.key = ctrl.new_key;
                entry_next.idx = ctrl.new_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hdl/crs_checker.sv @@
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks of the cost rank sorter, bound to the top level.
// ----------------------------------------------------------------------------
module crs_checker
    import crs_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     s_is_last,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [IDX_W-1:0]         m_location_index,
    input logic                     m_last_rank,
    input logic signed [COST_W-1:0] m_max_finite_cost,
    input logic                     m_none_finite,
    input logic                     m_overflowed
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_location_index)
            && $stable(m_last_rank))
        else $error("result beat changed while stalled");

    a_drain_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_last |=> !s_ready)
        else $error("input taken right after last beat");

    a_summary_final_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_rank |-> (m_max_finite_cost == '0) && !m_none_finite
            && !m_overflowed)
        else $error("summary fields set on a non-final beat");

    a_none_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_none_finite |-> m_max_finite_cost == $signed(COST_MOST_NEG))
        else $error("no finite cost but maximum not most negative");

endmodule

bind cost_rank_sorter crs_checker u_crs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_is_last         (s_is_last),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_location_index  (m_location_index),
    .m_last_rank       (m_last_rank),
    .m_max_finite_cost (m_max_finite_cost),
    .m_none_finite     (m_none_finite),
    .m_overflowed      (m_overflowed)
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for cost_rank_sorter. Streams runs of signed costs into
// the block and checks that every index beat, and the run totals on the
// final beat, match a built-in sorted-store predictor. It opens with a table
// of directed rows, then moves on to random runs. The random runs include
// ceiling changes, a run that overflows the store, a long receiver hold-off
// and random gaps on both sides.
// ----------------------------------------------------------------------------
module tb;
    import crs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] REG_UNMAPPED = 3'd4;
    localparam int RANDOM_ITEMS    = 150;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_GUARD     = 16;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 1000;

    typedef struct packed {
        logic [IDX_W-1:0]  loc;
        logic              last_rank;
        logic [COST_W-1:0] max_cost;
        logic              none_finite;
        logic              overflowed;
    } rank_beat_t;

    typedef enum logic {
        ROW_COST,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [PADDR_W-1:0] addr;
        logic [COST_W-1:0]  value;
        logic               last;
        logic               typed;
        rank_beat_t         want;
    } stim_row_t;

    localparam rank_beat_t NO_WANT = '0;

    localparam stim_row_t DIRECTED [23] = '{
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0000, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_COST,  REG_COST_CEILING, 32'h7FFF_FFFF, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h8000_0000, 1'b1, 1'b0}},
        '{ROW_COST,  REG_COST_CEILING, 32'h8000_0000, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h8000_0000, 1'b0, 1'b0}},
        '{ROW_COST,  REG_COST_CEILING, 32'h7FFF_FFFE, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h7FFF_FFFE, 1'b0, 1'b0}},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0005, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'hFFFF_FFFD, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0005, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h8000_0000, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0000, 1'b1, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_COST_CEILING, 32'h8000_0000, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h8000_0000, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h8000_0000, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_UNMAPPED,     32'h0000_0000, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'hFFFF_FFFF, 1'b1, 1'b1,
          '{6'd0, 1'b1, 32'h8000_0000, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_COST_CEILING, 32'h0000_0064, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0032, 1'b0, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_COST_CEILING, 32'h0000_000A, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_003C, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0005, 1'b1, 1'b0, NO_WANT},
        '{ROW_WRITE, REG_COST_CEILING, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0001, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0001, 1'b0, 1'b0, NO_WANT},
        '{ROW_COST,  REG_COST_CEILING, 32'h0000_0000, 1'b1, 1'b0, NO_WANT}
    };

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COST_W-1:0]  s_cost = '0;
    logic                      s_is_last = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [IDX_W-1:0]          m_location_index;
    logic                      m_last_rank;
    logic signed [COST_W-1:0]  m_max_finite_cost;
    logic                      m_none_finite;
    logic                      m_overflowed;

    logic       row_typed = 1'b0;
    rank_beat_t row_want = '0;
    bit         no_gaps = 1'b0;
    bit         hold_off_armed = 1'b0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    logic signed [COST_W-1:0] sorted_cost [MAX_LOCATIONS_DEF];
    logic [IDX_W-1:0]         sorted_loc [MAX_LOCATIONS_DEF];
    logic [6:0]               loaded = '0;
    logic signed [COST_W-1:0] top_finite = COST_MOST_NEG;
    logic                     any_finite = 1'b0;
    logic                     dropped = 1'b0;
    logic signed [COST_W-1:0] ceiling = COST_MOST_POS;
    rank_beat_t               pending_ranks [$];

    cost_rank_sorter dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cost            (s_cost),
        .s_is_last         (s_is_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_location_index  (m_location_index),
        .m_last_rank       (m_last_rank),
        .m_max_finite_cost (m_max_finite_cost),
        .m_none_finite     (m_none_finite),
        .m_overflowed      (m_overflowed)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h", $time, what, got, want);
    endtask

    function automatic void rank_cost(input logic signed [COST_W-1:0] c, input logic last);
        int pos;
        rank_beat_t beat;
        if (loaded < MAX_LOCATIONS_DEF) begin
            pos = loaded;
            while (pos > 0 && sorted_cost[pos-1] > c) begin
                sorted_cost[pos] = sorted_cost[pos-1];
                sorted_loc[pos]  = sorted_loc[pos-1];
                pos--;
            end
            sorted_cost[pos] = c;
            sorted_loc[pos]  = loaded[IDX_W-1:0];
            loaded++;
            if (c < ceiling) begin
                if (!any_finite || c > top_finite)
                    top_finite = c;
                any_finite = 1'b1;
            end
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            for (int k = 0; k < loaded; k++) begin
                beat = '0;
                beat.loc = sorted_loc[k];
                if (k + 1 == loaded) begin
                    beat.last_rank   = 1'b1;
                    beat.max_cost    = any_finite ? top_finite : COST_MOST_NEG;
                    beat.none_finite = !any_finite;
                    beat.overflowed  = dropped;
                end
                pending_ranks.push_back(beat);
            end
            loaded     = '0;
            top_finite = COST_MOST_NEG;
            any_finite = 1'b0;
            dropped    = 1'b0;
        end
    endfunction

    task automatic check_rank_beat();
        rank_beat_t want;
        if (pending_ranks.size() == 0) begin
            report_mismatch("beat with no rank pending", 32'(m_location_index), '0);
            return;
        end
        want = pending_ranks.pop_front();
        if (m_location_index != want.loc)
            report_mismatch("location_index", 32'(m_location_index), 32'(want.loc));
        if (m_last_rank != want.last_rank)
            report_mismatch("last_rank", 32'(m_last_rank), 32'(want.last_rank));
        if (m_max_finite_cost != want.max_cost)
            report_mismatch("max_finite_cost", m_max_finite_cost, want.max_cost);
        if (m_none_finite != want.none_finite)
            report_mismatch("none_finite", 32'(m_none_finite), 32'(want.none_finite));
        if (m_overflowed != want.overflowed)
            report_mismatch("overflowed", 32'(m_overflowed), 32'(want.overflowed));
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready && paddr == REG_COST_CEILING)
                ceiling = pwdata;
            if (s_valid && s_ready) begin
                rank_cost(s_cost, s_is_last);
                if (row_typed && s_is_last) begin
                    void'(pending_ranks.pop_back());
                    pending_ranks.push_back(row_want);
                end
            end
            if (m_valid && m_ready)
                check_rank_beat();
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off while the store backs up
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_armed && m_valid) begin
                hold_off_armed = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_ready <= no_gaps || ($urandom_range(99, 0) >= 37);
            @(posedge aclk);
        end
    end

    task automatic push_cost(input logic [COST_W-1:0] c, input logic last,
                             input logic typed, input rank_beat_t want);
        while (!no_gaps && $urandom_range(99, 0) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cost    <= c;
        s_is_last <= last;
        row_typed <= typed;
        row_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic write, input logic [PADDR_W-1:0] addr,
                                input logic [PDATA_W-1:0] data,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reconfigure(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        logic [PDATA_W-1:0] readback;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_ranks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_transfer(1'b1, addr, data, readback);
        apb_transfer(1'b0, REG_COST_CEILING, '0, readback);
        if (readback != ceiling)
            report_mismatch("cost_ceiling readback", readback, ceiling);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(7, 0))
            0, 1:    return $urandom;
            2, 3:    return 32'($urandom_range(16, 0)) - 32'd8;
            4:       return $urandom_range(1, 0) ? COST_MOST_POS : COST_MOST_NEG;
            default: return 32'($urandom_range(4000, 0)) - 32'd2000;
        endcase
    endfunction

    function automatic logic [COST_W-1:0] pick_ceiling();
        case ($urandom_range(4, 0))
            0:       return COST_MOST_POS;
            1:       return COST_MOST_NEG;
            2:       return $urandom;
            default: return 32'($urandom_range(4000, 0)) - 32'd2000;
        endcase
    endfunction

    initial begin
        int  made;
        int  run_len;
        int  big_at;
        bit  big_done;
        bit  skip_write;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_WRITE)
                reconfigure(DIRECTED[i].addr, DIRECTED[i].value);
            else
                push_cost(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed,
                          DIRECTED[i].want);
        end

        made       = 0;
        big_done   = 1'b0;
        skip_write = 1'b0;
        big_at     = $urandom_range(80, 20);
        while (made < RANDOM_ITEMS) begin
            if (!skip_write && $urandom_range(2, 0) == 0) begin
                if ($urandom_range(5, 0) == 0)
                    reconfigure(REG_UNMAPPED, $urandom);
                else
                    reconfigure(REG_COST_CEILING, pick_ceiling());
            end
            skip_write = 1'b0;
            if (!big_done && made >= big_at) begin
                // overflow the store; keep offering while the receiver holds off
                run_len        = MAX_LOCATIONS_DEF + 2;
                big_done       = 1'b1;
                skip_write     = 1'b1;
                hold_off_armed = 1'b1;
            end else begin
                run_len = $urandom_range(12, 1);
            end
            for (int k = 1; k <= run_len; k++) begin
                no_gaps = (made >= 100 && made < 150);
                push_cost(pick_cost(), k == run_len, 1'b0, NO_WANT);
                made++;
            end
        end

        no_gaps = 1'b0;
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_ranks.size() != 0);
        repeat (DRAIN_GUARD) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
